### src/tsdr_pkg.sv
// ----------------------------------------------------------------------------
// tsdr_pkg: shared definitions for the two-sensor dead-reckoning block
// Widths, reset values, the CORDIC arctangent table and the sequencer states.
// ----------------------------------------------------------------------------
package tsdr_pkg;

  localparam int CORDIC_STEPS = 16;          // legal range 8 .. 30
  localparam int CNT_W        = $clog2(CORDIC_STEPS);

  localparam int VALUE_W   = 16;
  localparam int GAIN_W    = 24;
  localparam int HEAD_W    = 32;
  localparam int POS_W     = 48;
  localparam int TRIG_W    = 34;             // Q2.30 with headroom
  localparam int ANG_W     = 33;             // CORDIC residual angle
  localparam int PROD_W    = VALUE_W + TRIG_W;
  localparam int FRAC_DROP = 14;             // Q.30 product down to Q.16
  localparam int INC_W     = PROD_W - FRAC_DROP;

  localparam logic [GAIN_W-1:0] TURN_GAIN_RESET = 24'd170891;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = 50'sd8192;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef logic signed [ANG_W-1:0]  ang_t;

  typedef enum logic [3:0] {
    S_IDLE,   // waiting for a request
    S_TURN,   // multiplier forms value * turn_gain
    S_HEAD,   // heading update
    S_PREP,   // quadrant reduction and CORDIC seed
    S_ROT,    // CORDIC micro-rotations
    S_QUAD,   // quadrant rotation, pick the trig term for each axis
    S_MULA,   // multiplier forms value * x term
    S_ACCX,   // x accumulate, multiplier forms value * y term
    S_ACCY,   // y accumulate
    S_PUB     // hand the pose to the output register
  } state_t;

  // Arctangent of 2^-i in binary-angle units, rounded to nearest.
  function automatic ang_t atan_brad(input logic [4:0] idx);
    ang_t a;
    case (idx)
      5'd0:  a = 33'sd536870912;
      5'd1:  a = 33'sd316933406;
      5'd2:  a = 33'sd167458907;
      5'd3:  a = 33'sd85004756;
      5'd4:  a = 33'sd42667331;
      5'd5:  a = 33'sd21354465;
      5'd6:  a = 33'sd10679838;
      5'd7:  a = 33'sd5340245;
      5'd8:  a = 33'sd2670163;
      5'd9:  a = 33'sd1335087;
      5'd10: a = 33'sd667544;
      5'd11: a = 33'sd333772;
      5'd12: a = 33'sd166886;
      5'd13: a = 33'sd83443;
      5'd14: a = 33'sd41722;
      5'd15: a = 33'sd20861;
      5'd16: a = 33'sd10430;
      5'd17: a = 33'sd5215;
      5'd18: a = 33'sd2608;
      5'd19: a = 33'sd1304;
      5'd20: a = 33'sd652;
      5'd21: a = 33'sd326;
      5'd22: a = 33'sd163;
      5'd23: a = 33'sd81;
      5'd24: a = 33'sd41;
      5'd25: a = 33'sd20;
      5'd26: a = 33'sd10;
      5'd27: a = 33'sd5;
      5'd28: a = 33'sd3;
      5'd29: a = 33'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### src/two_sensor_dead_reckoning.sv
// ----------------------------------------------------------------------------
// two_sensor_dead_reckoning: pose integrator for two relative motion sensors
// Folds left/right forward and lateral motion counts into a heading and an
// x/y position, using an iterative CORDIC and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the in_ channel carries one motion report: the sensor
//   (in_source), the axis (in_axis) and a signed count (in_value). It is taken
//   at a rising edge with in_valid high and in_stall low. Each request gives
//   exactly one result on the out_ channel: the updated pose (out_pos_x,
//   out_pos_y in Q32.16, out_heading as a 32-bit binary angle).
//   A new request is taken only after the previous result has gone to the
//   output register and the sequencer is back in idle. The CORDIC runs one
//   micro-rotation per cycle, and each request makes three passes through
//   the single shared multiplier (turn, x term, y term).
//   The result sits in an output register, so the next request is accepted
//   while it waits. If the receiver still stalls when the following result is
//   ready, the sequencer holds that result and keeps in_stall high until the
//   output register frees up.
//   turn_gain is written through cfg_we/cfg_wdata. The user must write it
//   only while the block is idle; the block itself does not enforce this.
//   Synchronous reset clears the pose to zero, reloads turn_gain with its
//   default and empties the output register.
// ----------------------------------------------------------------------------
module two_sensor_dead_reckoning (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_source,
  input  logic                                   in_axis,
  input  logic signed [tsdr_pkg::VALUE_W-1:0]    in_value,
  // result channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [tsdr_pkg::POS_W-1:0]      out_pos_x,
  output logic signed [tsdr_pkg::POS_W-1:0]      out_pos_y,
  output logic signed [tsdr_pkg::HEAD_W-1:0]     out_heading,
  // configuration
  input  logic                                   cfg_we,
  input  logic [tsdr_pkg::GAIN_W-1:0]            cfg_wdata
);
  import tsdr_pkg::*;

  // Multiplier B operand selection.
  typedef enum logic [1:0] {
    MB_GAIN,
    MB_TERM_A,
    MB_TERM_B
  } mul_sel_t;

  typedef struct packed {
    logic     accept;     // capture the request
    logic     mul_en;     // load the product register
    mul_sel_t mul_sel;
    logic     head_en;    // apply the turn to the heading
    logic     seed_en;    // quadrant reduction and CORDIC seed
    logic     rot_en;     // one CORDIC micro-rotation
    logic     quad_en;    // quadrant rotation into the trig terms
    logic     x_en;       // accumulate x
    logic     y_en;       // accumulate y
    logic     publish;    // load the output register
  } ctrl_t;

  state_t state_r, state_nxt;
  ctrl_t  ctl;

  logic [GAIN_W-1:0]         turn_gain_r;
  logic                      source_r, axis_r;
  logic signed [VALUE_W-1:0] value_r;

  logic [HEAD_W-1:0]         heading_r;
  logic signed [POS_W-1:0]   x_acc_r, y_acc_r;

  logic [1:0]                quad_r;
  logic [CNT_W-1:0]          cnt_r;
  trig_t                     cx_r, cy_r;
  ang_t                      cz_r;
  trig_t                     term_a_r, term_b_r;   // x term, y term
  logic signed [PROD_W-1:0]  prod_r;

  logic                      out_valid_r;
  logic signed [POS_W-1:0]   out_pos_x_r, out_pos_y_r;
  logic [HEAD_W-1:0]         out_heading_r;

  logic                      out_free;
  logic                      rot_last;

  assign out_free = !out_valid_r || !out_stall;
  assign rot_last = (cnt_r == CNT_W'(CORDIC_STEPS - 1));

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_TURN;
      S_TURN: state_nxt = S_HEAD;
      S_HEAD: state_nxt = S_PREP;
      S_PREP: state_nxt = S_ROT;
      S_ROT:  if (rot_last) state_nxt = S_QUAD;
      S_QUAD: state_nxt = S_MULA;
      S_MULA: state_nxt = S_ACCX;
      S_ACCX: state_nxt = S_ACCY;
      S_ACCY: state_nxt = S_PUB;
      S_PUB:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    ctl = '0;
    ctl.mul_sel = MB_GAIN;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        ctl.accept = in_valid;
      end
      S_TURN: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MB_GAIN;
      end
      S_HEAD: ctl.head_en = 1'b1;
      S_PREP: ctl.seed_en = 1'b1;
      S_ROT:  ctl.rot_en  = 1'b1;
      S_QUAD: ctl.quad_en = 1'b1;
      S_MULA: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MB_TERM_A;
      end
      S_ACCX: begin
        ctl.x_en    = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = MB_TERM_B;
      end
      S_ACCY: ctl.y_en = 1'b1;
      S_PUB:  ctl.publish = out_free;
      default: ctl = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared multiplier: the count times the turn gain or a trig term.
  // --------------------------------------------------------------------------
  trig_t                    mul_b;
  logic signed [PROD_W-1:0] prod_nxt;

  always_comb begin
    case (ctl.mul_sel)
      MB_GAIN:   mul_b = trig_t'({{(TRIG_W - GAIN_W){1'b0}}, turn_gain_r});
      MB_TERM_A: mul_b = term_a_r;
      MB_TERM_B: mul_b = term_b_r;
      default:   mul_b = '0;
    endcase
  end

  assign prod_nxt = PROD_W'(value_r) * PROD_W'(mul_b);

  // Rounded position increment from the last product, and the saturating sums.
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [INC_W-1:0]  inc;
  logic signed [POS_W:0]    x_sum, y_sum;
  logic signed [POS_W-1:0]  x_sat, y_sat;

  assign prod_rnd = prod_r + ROUND_HALF;
  assign inc      = prod_rnd[PROD_W-1:FRAC_DROP];
  assign x_sum    = (POS_W+1)'(x_acc_r) + (POS_W+1)'(inc);
  assign y_sum    = (POS_W+1)'(y_acc_r) + (POS_W+1)'(inc);

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] s);
    logic signed [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1])
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      r = s[POS_W-1:0];
    return r;
  endfunction

  assign x_sat = sat_pos(x_sum);
  assign y_sat = sat_pos(y_sum);

  // --------------------------------------------------------------------------
  // Heading update and quadrant reduction
  // --------------------------------------------------------------------------
  logic [HEAD_W-1:0] turn;
  logic [HEAD_W-1:0] head_bias;
  logic [1:0]        quad;
  logic [HEAD_W-1:0] resid;

  assign turn      = prod_r[HEAD_W-1:0];
  assign head_bias = heading_r + 32'h2000_0000;
  assign quad      = head_bias[HEAD_W-1:HEAD_W-2];
  assign resid     = heading_r - {quad, {(HEAD_W-2){1'b0}}};

  // --------------------------------------------------------------------------
  // CORDIC micro-rotation, one per cycle
  // --------------------------------------------------------------------------
  trig_t xs, ys;
  ang_t  step_ang;

  assign xs       = cx_r >>> cnt_r;
  assign ys       = cy_r >>> cnt_r;
  assign step_ang = atan_brad(5'(cnt_r));

  // Quadrant rotation applied to the CORDIC result.
  trig_t cos_v, sin_v;

  always_comb begin
    case (quad_r)
      2'd0: begin
        cos_v = cx_r;
        sin_v = cy_r;
      end
      2'd1: begin
        cos_v = -cy_r;
        sin_v = cx_r;
      end
      2'd2: begin
        cos_v = -cx_r;
        sin_v = -cy_r;
      end
      default: begin
        cos_v = cy_r;
        sin_v = -cx_r;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      turn_gain_r <= TURN_GAIN_RESET;
      heading_r   <= '0;
      x_acc_r     <= '0;
      y_acc_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        turn_gain_r <= cfg_wdata;
      end
      if (ctl.head_en && !axis_r) begin
        heading_r <= source_r ? heading_r + turn : heading_r - turn;
      end
      if (ctl.x_en) begin
        x_acc_r <= x_sat;
      end
      if (ctl.y_en) begin
        y_acc_r <= y_sat;
      end
      if (ctl.seed_en) begin
        cnt_r <= '0;
      end else if (ctl.rot_en) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (ctl.publish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      source_r <= in_source;
      axis_r   <= in_axis;
      value_r  <= in_value;
    end
    if (ctl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctl.seed_en) begin
      quad_r <= quad;
      cx_r   <= CORDIC_X0;
      cy_r   <= '0;
      cz_r   <= ang_t'(signed'(resid));
    end else if (ctl.rot_en) begin
      if (!cz_r[ANG_W-1]) begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - step_ang;
      end else begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + step_ang;
      end
    end
    if (ctl.quad_en) begin
      // Forward motion uses (cos, sin); lateral motion uses (sin, cos).
      term_a_r <= axis_r ? sin_v : cos_v;
      term_b_r <= axis_r ? cos_v : sin_v;
    end
    if (ctl.publish) begin
      out_pos_x_r   <= x_acc_r;
      out_pos_y_r   <= y_acc_r;
      out_heading_r <= heading_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pos_x   = out_pos_x_r;
  assign out_pos_y   = out_pos_y_r;
  assign out_heading = signed'(out_heading_r);

`ifndef NO_ASSERTIONS
  // An accepted request always starts the turn multiply.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_TURN))
    else $error("accepted request did not start the sequencer");

  // After its last rotation the CORDIC goes on to the quadrant step.
  a_rot_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROT && rot_last) |=> (state_r == S_QUAD))
    else $error("CORDIC did not end after the last step");

  // A lateral report never turns the heading.
  a_lateral_keeps_heading: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_HEAD && axis_r) |=> $stable(heading_r))
    else $error("lateral report changed the heading");

  // A new result only appears from the publish step.
  a_valid_from_publish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUB))
    else $error("result raised outside the publish step");

  // The pose only moves while a request is being worked on.
  a_pose_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |=> ($stable(x_acc_r) && $stable(y_acc_r)))
    else $error("position changed while idle");
`endif

endmodule

### bench/tsdr_pose_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsdr_pose_checker: pose predictor and result checker
// Watches the request, result and gain-write ports of the dead-reckoning
// block, predicts the pose after every accepted request and compares each
// result against the oldest prediction.
// ----------------------------------------------------------------------------
package tsdr_tb_pkg;

  typedef enum logic {SRC_LEFT = 1'b0, SRC_RIGHT = 1'b1} sensor_e;
  typedef enum logic {AXIS_FORWARD = 1'b0, AXIS_LATERAL = 1'b1} axis_e;

  typedef struct packed {
    logic signed [tsdr_pkg::POS_W-1:0]  pos_x;
    logic signed [tsdr_pkg::POS_W-1:0]  pos_y;
    logic        [tsdr_pkg::HEAD_W-1:0] heading;
  } pose_t;

endpackage

module tsdr_pose_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic                                in_source,
  input  logic                                in_axis,
  input  logic signed [tsdr_pkg::VALUE_W-1:0] in_value,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [tsdr_pkg::POS_W-1:0]   out_pos_x,
  input  logic signed [tsdr_pkg::POS_W-1:0]   out_pos_y,
  input  logic signed [tsdr_pkg::HEAD_W-1:0]  out_heading,
  input  logic                                cfg_we,
  input  logic [tsdr_pkg::GAIN_W-1:0]         cfg_wdata,
  output int                                  mismatches,
  output int                                  outstanding
);
  import tsdr_pkg::*;
  import tsdr_tb_pkg::*;

  localparam longint CORDIC_SEED = 652032874;
  localparam logic signed [63:0] POS_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] POS_LO = 64'shFFFF_8000_0000_0000;

  // Arctangent of 2^-i as a binary angle (2^32 per turn), rounded to nearest.
  longint atan_rom [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1
  };

  logic [GAIN_W-1:0]  gain_q;
  logic [HEAD_W-1:0]  heading_q;
  logic signed [63:0] x_q;
  logic signed [63:0] y_q;
  pose_t              pending_poses [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Count times a Q2.30 trig term, rounded to the nearest Q.16 step.
  function automatic logic signed [63:0] scale_count(input logic signed [63:0] v,
                                                     input logic signed [63:0] t);
    return (v * t + 64'sd8192) >>> 14;
  endfunction

  function automatic logic signed [63:0] clamp_pos(input logic signed [63:0] sum);
    if (sum > POS_HI) return POS_HI;
    if (sum < POS_LO) return POS_LO;
    return sum;
  endfunction

  // Folds one motion report into the tracked pose and returns the new pose.
  function automatic pose_t advance_pose(input logic src, input logic ax,
                                         input logic signed [VALUE_W-1:0] val);
    logic signed [63:0] v, turn, cx, sy, xs, ys, z, c, s;
    logic [31:0]        quad, resid;
    pose_t              p;
    v = val;
    if (ax == AXIS_FORWARD) begin
      turn = v * $signed({40'd0, gain_q});
      if (src == SRC_RIGHT) heading_q = heading_q + turn[31:0];
      else heading_q = heading_q - turn[31:0];
    end
    // Reduce to the nearest quadrant, then rotate the residual.
    quad  = (heading_q + 32'h2000_0000) >> 30;
    resid = heading_q - (quad << 30);
    z     = $signed(resid);
    cx    = CORDIC_SEED;
    sy    = 0;
    for (int i = 0; i < CORDIC_STEPS && i < 30; i++) begin
      xs = cx >>> i;
      ys = sy >>> i;
      if (z >= 0) begin
        cx = cx - ys;
        sy = sy + xs;
        z  = z - atan_rom[i];
      end else begin
        cx = cx + ys;
        sy = sy - xs;
        z  = z + atan_rom[i];
      end
    end
    case (quad)
      0: begin c = cx;  s = sy;  end
      1: begin c = -sy; s = cx;  end
      2: begin c = -cx; s = -sy; end
      default: begin c = sy; s = -cx; end
    endcase
    if (ax == AXIS_FORWARD) begin
      x_q = clamp_pos(x_q + scale_count(v, c));
      y_q = clamp_pos(y_q + scale_count(v, s));
    end else begin
      x_q = clamp_pos(x_q + scale_count(v, s));
      y_q = clamp_pos(y_q + scale_count(v, c));
    end
    p.pos_x   = x_q[POS_W-1:0];
    p.pos_y   = y_q[POS_W-1:0];
    p.heading = heading_q;
    return p;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: pose mismatch on %s: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    pose_t want;
    if (!rst_n) begin
      gain_q    = TURN_GAIN_RESET;
      heading_q = '0;
      x_q       = '0;
      y_q       = '0;
      pending_poses.delete();
    end else begin
      if (cfg_we) gain_q = cfg_wdata;
      // Retire a result before queueing a new request taken on the same edge.
      if (out_valid && !out_stall) begin
        if (pending_poses.size() == 0) begin
          report_mismatch("result with nothing pending", out_pos_x, 64'd0);
        end else begin
          want = pending_poses.pop_front();
          if (out_pos_x !== want.pos_x) report_mismatch("pos_x", out_pos_x, want.pos_x);
          if (out_pos_y !== want.pos_y) report_mismatch("pos_y", out_pos_y, want.pos_y);
          if (out_heading !== want.heading)
            report_mismatch("heading", out_heading, want.heading);
        end
      end
      if (in_valid && !in_stall)
        pending_poses.push_back(advance_pose(in_source, in_axis, in_value));
    end
    outstanding <= pending_poses.size();
  end

endmodule

### bench/two_sensor_dead_reckoning_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_sensor_dead_reckoning_tb: top-level bench for the pose integrator
// Drives motion requests and turn-gain writes into the block, applies random
// and prolonged back-pressure on the result side, and lets the pose checker
// judge every result. Prints the verdict when all requests have drained.
// ----------------------------------------------------------------------------
module two_sensor_dead_reckoning_tb;
  import tsdr_pkg::*;
  import tsdr_tb_pkg::*;

  // Time that one request takes through the block.
  localparam int SLOT_CYCLES = CORDIC_STEPS + 9;

  // Length of the opening forward run, sent with no idling on either side.
  localparam int STEADY_REPORTS = 100;

  // The receiver holds off once, partway into the random part, long enough
  // for the block to fill its output register and push back on requests.
  localparam int HOLD_AT     = STEADY_REPORTS + 250;
  localparam int HOLD_CYCLES = 400;

  // Generous bound on the length of the whole run, even with heavy stalls
  // and the long hold-off.
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;

  logic                      clk;
  logic                      rst_n       = 1'b0;
  logic                      in_valid    = 1'b0;
  logic                      in_stall;
  logic                      in_source   = 1'b0;
  logic                      in_axis     = 1'b0;
  logic signed [VALUE_W-1:0] in_value    = '0;
  logic                      out_valid;
  logic                      out_stall   = 1'b0;
  logic signed [POS_W-1:0]   out_pos_x;
  logic signed [POS_W-1:0]   out_pos_y;
  logic signed [HEAD_W-1:0]  out_heading;
  logic                      cfg_we      = 1'b0;
  logic [GAIN_W-1:0]         cfg_wdata   = '0;

  // While steady is set, neither side idles.
  logic                      steady      = 1'b0;
  int                        mismatches;
  int                        outstanding;

  two_sensor_dead_reckoning dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_source   (in_source),
    .in_axis     (in_axis),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_heading (out_heading),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata)
  );

  tsdr_pose_checker pose_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_source   (in_source),
    .in_axis     (in_axis),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pos_x   (out_pos_x),
    .out_pos_y   (out_pos_y),
    .out_heading (out_heading),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog. A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    int cycles;
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side. It stalls on about one cycle in five, not at all while the
  // bench runs steady, and once holds off for a long stretch that it counts
  // itself so that the sender keeps pushing requests into a full block.
  always @(posedge clk) begin
    int results_seen;
    int hold_left;
    bit hold_done;
    if (rst_n && out_valid && !out_stall) results_seen++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen == HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 20);
    end
  end

  // Offers one motion request and returns on the edge that accepts it. The
  // valid stays high afterwards so that back-to-back requests never see it
  // drop and rise within one time step.
  task automatic send_report(input sensor_e src, input axis_e ax,
                             input logic signed [VALUE_W-1:0] val);
    while (!steady && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_source <= src;
    in_axis   <= ax;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted pose has come back. The
  // checker's count is registered, so the task lets the next edge pass first.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // The gain register is only written while the block is idle.
  task automatic load_gain(input logic [GAIN_W-1:0] gain);
    settle_block();
    cfg_wdata <= gain;
    cfg_we    <= 1'b1;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random requests: mostly full-range counts, with the count extremes and
  // small steps mixed in, on either sensor and either axis.
  task automatic random_reports(input int count);
    logic signed [VALUE_W-1:0] val;
    repeat (count) begin
      case ($urandom_range(7))
        0: val = 16'sh7FFF;
        1: val = 16'sh8000;
        2: val = 16'($urandom_range(15));
        3: val = -16'($urandom_range(15));
        default: val = 16'($urandom);
      endcase
      send_report(sensor_e'($urandom_range(1)), axis_e'($urandom_range(1)), val);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With a zero gain the heading stays at zero, so a forward run at full
    // count walks x straight up. This is the long stretch without idling.
    load_gain('0);
    steady <= 1'b1;
    repeat (STEADY_REPORTS)
      send_report(sensor_e'($urandom_range(1)), AXIS_FORWARD, 16'sh7FFF);
    steady <= 1'b0;

    // Directed requests at the largest gain: both count extremes on both
    // sensors forward, each once laterally. A full-scale count times the
    // largest gain wraps the heading many times over on the first request.
    load_gain(GAIN_MAX);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sh7FFF);
    send_report(SRC_LEFT,  AXIS_FORWARD, 16'sh7FFF);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sh8000);
    send_report(SRC_LEFT,  AXIS_FORWARD, 16'sh8000);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sd1);
    send_report(SRC_LEFT,  AXIS_FORWARD, -16'sd1);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sd0);
    send_report(SRC_LEFT,  AXIS_FORWARD, 16'sd0);
    // Lateral requests ignore the sensor and leave the heading alone.
    send_report(SRC_LEFT,  AXIS_LATERAL, 16'sh7FFF);
    send_report(SRC_RIGHT, AXIS_LATERAL, 16'sh8000);
    send_report(SRC_LEFT,  AXIS_LATERAL, 16'sd0);
    send_report(SRC_RIGHT, AXIS_LATERAL, -16'sd1);
    send_report(SRC_LEFT,  AXIS_LATERAL, 16'sd1);

    // Back at the default gain, where 4000 counts make one radian.
    load_gain(TURN_GAIN_RESET);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sd4000);
    send_report(SRC_LEFT,  AXIS_FORWARD, 16'sd4000);
    send_report(SRC_RIGHT, AXIS_FORWARD, 16'sh8000);
    send_report(SRC_RIGHT, AXIS_LATERAL, 16'sh7FFF);
    send_report(SRC_LEFT,  AXIS_LATERAL, 16'sh8000);
    send_report(SRC_LEFT,  AXIS_FORWARD, 16'sd12345);

    // Random part, one gain setting per phase. Each gain change drains the
    // block first, which also makes the sender pause until all results are
    // back. The long receiver hold-off falls in the second phase.
    load_gain(GAIN_MAX);
    random_reports(150);
    load_gain(TURN_GAIN_RESET);
    random_reports(230);
    load_gain(GAIN_W'(1));
    random_reports(120);
    load_gain(GAIN_W'($urandom_range(GAIN_MAX)));
    random_reports(180);
    load_gain(GAIN_W'($urandom_range(4095)));
    random_reports(180);
    load_gain('0);
    random_reports(150);

    settle_block();
    repeat (2 * SLOT_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### two_sensor_dead_reckoning.f
src/tsdr_pkg.sv
src/two_sensor_dead_reckoning.sv
bench/tsdr_pose_checker.sv
bench/two_sensor_dead_reckoning_tb.sv
